// ----- rtl/core/pac_pkg.sv -----
// Shared types and constants for the proximity alarm controller.
package pac_pkg;

    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;
    localparam int NOW_IN_BITS   = 32;
    localparam int DIST_IN_BITS  = 16;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_WATCH = 2'd1,
        MODE_ALARM = 2'd2,
        MODE_TEST  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_ARM    = 2'd1,
        FUNC_DISARM = 2'd2,
        FUNC_TEST   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_COLOUR_A      = 3'd0,
        REG_COLOUR_B      = 3'd1,
        REG_BLINK_PERIOD  = 3'd2,
        REG_TRIGGER_DIST  = 3'd3,
        REG_CLEAR_TIMEOUT = 3'd4,
        REG_TEST_DURATION = 3'd5
    } reg_idx_t;

    localparam logic [7:0]  FULL_LEVEL = 8'd255;
    localparam logic [23:0] RED_ONLY   = {FULL_LEVEL, 16'd0};

    localparam logic [23:0] COLOUR_A_RST      = 24'hFF0000;
    localparam logic [23:0] COLOUR_B_RST      = 24'h0000FF;
    localparam logic [15:0] BLINK_PERIOD_RST  = 16'd250;
    localparam logic [15:0] TRIGGER_DIST_RST  = 16'd1500;
    localparam logic [31:0] CLEAR_TIMEOUT_RST = 32'd3000;
    localparam logic [31:0] TEST_DURATION_RST = 32'd3000;

    typedef struct packed {
        logic [23:0] colour_a;
        logic [23:0] colour_b;
        logic [15:0] blink_period_ms;
        logic [15:0] trigger_distance;
        logic [31:0] clear_timeout_ms;
        logic [31:0] test_duration_ms;
    } pac_cfg_t;

    typedef struct packed {
        func_t                   func;
        logic [NOW_IN_BITS-1:0]  now_ms;
        logic [DIST_IN_BITS-1:0] distance_reading;
        logic                    distance_valid;
    } pac_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       buzzer_on;
        mode_t      mode;
    } pac_result_t;

endpackage

// ----- rtl/core/pac_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface pac_item_if import pac_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              func;
    logic [NOW_IN_BITS-1:0]  now_ms;
    logic [DIST_IN_BITS-1:0] distance_reading;
    logic                    distance_valid;

    modport source (
        output valid, func, now_ms, distance_reading, distance_valid,
        input  ready
    );
    modport sink (
        input  valid, func, now_ms, distance_reading, distance_valid,
        output ready
    );
endinterface

interface pac_result_if import pac_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       buzzer_on;
    logic [1:0] mode;

    modport source (
        output valid, red, green, blue, buzzer_on, mode,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, buzzer_on, mode,
        output ready
    );
endinterface

// ----- rtl/core/pac_regs.sv -----
// APB configuration register file.
module pac_regs import pac_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output pac_cfg_t                 cfg
);

    pac_cfg_t cfg_reg;
    pac_cfg_t cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_COLOUR_A:      cfg_next.colour_a         = pwdata[23:0];
                REG_COLOUR_B:      cfg_next.colour_b         = pwdata[23:0];
                REG_BLINK_PERIOD:  cfg_next.blink_period_ms  = pwdata[15:0];
                REG_TRIGGER_DIST:  cfg_next.trigger_distance = pwdata[15:0];
                REG_CLEAR_TIMEOUT: cfg_next.clear_timeout_ms = pwdata;
                REG_TEST_DURATION: cfg_next.test_duration_ms = pwdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_COLOUR_A:      prdata = {8'd0, cfg_reg.colour_a};
            REG_COLOUR_B:      prdata = {8'd0, cfg_reg.colour_b};
            REG_BLINK_PERIOD:  prdata = {16'd0, cfg_reg.blink_period_ms};
            REG_TRIGGER_DIST:  prdata = {16'd0, cfg_reg.trigger_distance};
            REG_CLEAR_TIMEOUT: prdata = cfg_reg.clear_timeout_ms;
            REG_TEST_DURATION: prdata = cfg_reg.test_duration_ms;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.colour_a         <= COLOUR_A_RST;
            cfg_reg.colour_b         <= COLOUR_B_RST;
            cfg_reg.blink_period_ms  <= BLINK_PERIOD_RST;
            cfg_reg.trigger_distance <= TRIGGER_DIST_RST;
            cfg_reg.clear_timeout_ms <= CLEAR_TIMEOUT_RST;
            cfg_reg.test_duration_ms <= TEST_DURATION_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/pac_core.sv -----
// Mode state machine, timers and LED/buzzer state for one item per cycle while step_en is high.
module pac_core import pac_pkg::*; #(
    parameter int TIME_BITS = 32,
    parameter int DIST_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  pac_item_t   item,
    input  pac_cfg_t    cfg,
    output pac_result_t result_next
);

    mode_t                mode_reg, mode_next;
    logic                 arm_reg, arm_next;
    logic                 disarm_reg, disarm_next;
    logic [TIME_BITS-1:0] toggle_time_reg, toggle_time_next;
    logic [TIME_BITS-1:0] detect_time_reg, detect_time_next;
    logic [TIME_BITS-1:0] test_time_reg, test_time_next;
    logic                 phase_reg, phase_next;
    logic [23:0]          led_reg, led_next;
    logic                 buzzer_reg, buzzer_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] toggle_elapsed, detect_elapsed, test_elapsed;
    logic [DIST_BITS-1:0] dist_t, trig_t;
    logic                 near, far, toggle_due, clear_due, test_running;

    assign now_t          = TIME_BITS'(item.now_ms);
    assign dist_t         = DIST_BITS'(item.distance_reading);
    assign trig_t         = DIST_BITS'(cfg.trigger_distance);
    assign toggle_elapsed = now_t - toggle_time_reg;
    assign detect_elapsed = now_t - detect_time_reg;
    assign test_elapsed   = now_t - test_time_reg;
    assign near           = item.distance_valid && (dist_t <= trig_t);
    assign far            = item.distance_valid && (dist_t > trig_t);
    assign toggle_due     = toggle_elapsed >= TIME_BITS'(cfg.blink_period_ms);
    assign clear_due      = detect_elapsed >= TIME_BITS'(cfg.clear_timeout_ms);
    assign test_running   = test_elapsed < TIME_BITS'(cfg.test_duration_ms);

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        unique case (item.func)
            FUNC_TEST:
                mode_next = MODE_TEST;
            FUNC_UPDATE:
            begin
                unique case (mode_reg)
                    MODE_OFF:
                        if (arm_reg)
                            mode_next = MODE_WATCH;
                    MODE_WATCH:
                    begin
                        if (near)
                            mode_next = MODE_ALARM;
                        if (disarm_reg)
                            mode_next = MODE_OFF;
                    end
                    MODE_ALARM:
                    begin
                        if (far && clear_due)
                            mode_next = MODE_WATCH;
                        if (disarm_reg)
                            mode_next = MODE_OFF;
                    end
                    MODE_TEST:
                        if (!test_running)
                            mode_next = MODE_OFF;
                    default:
                        mode_next = MODE_OFF;
                endcase
            end
            default:
                mode_next = mode_reg;
        endcase
    end

    // flags, timers and drive levels
    always_comb
    begin
        arm_next         = arm_reg;
        disarm_next      = disarm_reg;
        toggle_time_next = toggle_time_reg;
        detect_time_next = detect_time_reg;
        test_time_next   = test_time_reg;
        phase_next       = phase_reg;
        led_next         = led_reg;
        buzzer_next      = buzzer_reg;
        case (item.func)
            FUNC_ARM:
                arm_next = 1'b1;
            FUNC_DISARM:
                disarm_next = 1'b1;
            FUNC_TEST:
            begin
                test_time_next = now_t;
                led_next       = RED_ONLY;
                buzzer_next    = 1'b1;
            end
            default:
            begin
                case (mode_reg)
                    MODE_OFF:
                    begin
                        led_next    = '0;
                        buzzer_next = 1'b0;
                        arm_next    = 1'b0;
                    end
                    MODE_WATCH:
                    begin
                        led_next    = '0;
                        buzzer_next = 1'b0;
                        disarm_next = 1'b0;
                        if (near)
                            detect_time_next = now_t;
                    end
                    MODE_ALARM:
                    begin
                        buzzer_next = 1'b1;
                        disarm_next = 1'b0;
                        if (toggle_due)
                        begin
                            toggle_time_next = now_t;
                            phase_next       = !phase_reg;
                            led_next         = phase_reg ? cfg.colour_b : cfg.colour_a;
                        end
                        if (far)
                        begin
                            if (clear_due)
                            begin
                                led_next    = '0;
                                buzzer_next = 1'b0;
                            end
                        end
                        else
                            detect_time_next = now_t;
                    end
                    default:
                    begin
                        if (test_running)
                        begin
                            led_next    = RED_ONLY;
                            buzzer_next = 1'b1;
                        end
                        else
                        begin
                            led_next    = '0;
                            buzzer_next = 1'b0;
                        end
                    end
                endcase
            end
        endcase
    end

    assign result_next.red       = led_next[23:16];
    assign result_next.green     = led_next[15:8];
    assign result_next.blue      = led_next[7:0];
    assign result_next.buzzer_on = buzzer_next;
    assign result_next.mode      = mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_OFF;
            arm_reg         <= 1'b0;
            disarm_reg      <= 1'b0;
            toggle_time_reg <= '0;
            detect_time_reg <= '0;
            test_time_reg   <= '0;
            phase_reg       <= 1'b0;
            led_reg         <= '0;
            buzzer_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg        <= mode_next;
            arm_reg         <= arm_next;
            disarm_reg      <= disarm_next;
            toggle_time_reg <= toggle_time_next;
            detect_time_reg <= detect_time_next;
            test_time_reg   <= test_time_next;
            phase_reg       <= phase_next;
            led_reg         <= led_next;
            buzzer_reg      <= buzzer_next;
        end
    end

    a_test_enters: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.func == FUNC_TEST |=> mode_reg == MODE_TEST && buzzer_reg)
        else $error("test start did not enter test mode");

    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.func == FUNC_UPDATE && mode_reg == MODE_OFF
        |=> led_reg == '0 && !buzzer_reg && !arm_reg)
        else $error("update in off left drive active or arm pending");

    a_alarm_buzz: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.func == FUNC_UPDATE && mode_reg == MODE_ALARM
        && mode_next == MODE_ALARM |=> buzzer_reg)
        else $error("buzzer silent while alarm held");

endmodule

// ----- rtl/core/proximity_alarm_controller.sv -----
// Top level of the proximity alarm controller: channels, item stage and result stage.
//
// Each input item (update, arm request, disarm request or test start) is
// captured in an input register, processed by the mode state machine in
// pac_core, and its result (RGB drive, buzzer and mode) is held in a result
// register until taken. The result is offered once its item has passed
// from the input register into the result register. One item is accepted
// in every cycle while results are taken; a stalled result register holds
// the item stage, which in turn drops ready. The rate is set by the state
// update, which compares timestamp differences (modulo 2^TIME_BITS)
// against the configured periods. Configuration sits behind a 32-bit APB
// port with registers at byte addresses 0x00 to 0x14; write it only while
// the block is idle.
module proximity_alarm_controller import pac_pkg::*; #(
    parameter int TIME_BITS = 32,
    parameter int DIST_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    pac_item_if.sink                 item_in,
    pac_result_if.source             result_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    pac_cfg_t    cfg;
    pac_item_t   item_reg, item_next;
    logic        in_valid_reg, in_valid_next;
    pac_result_t result_reg, result_next;
    logic        out_valid_reg, out_valid_next;
    logic        advance;
    logic        step_en;

    pac_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pac_core #(
        .TIME_BITS (TIME_BITS),
        .DIST_BITS (DIST_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .item        (item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    // Advance the item stage whenever the result register is free or being emptied.
    assign advance       = !out_valid_reg || result_out.ready;
    assign step_en       = in_valid_reg && advance;
    assign item_in.ready = !in_valid_reg || advance;

    always_comb
    begin
        item_next.func             = func_t'(item_in.func);
        item_next.now_ms           = item_in.now_ms;
        item_next.distance_reading = item_in.distance_reading;
        item_next.distance_valid   = item_in.distance_valid;
        // take a new item when ready, else hold the one in the stage
        in_valid_next  = item_in.ready ? item_in.valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
            item_reg <= item_next;
        if (step_en)
            result_reg <= result_next;
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.red       = result_reg.red;
    assign result_out.green     = result_reg.green;
    assign result_out.blue      = result_reg.blue;
    assign result_out.buzzer_on = result_reg.buzzer_on;
    assign result_out.mode      = result_reg.mode;

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_in.ready |-> in_valid_reg && out_valid_reg && !result_out.ready)
        else $error("input stalled without a stalled result");

    a_step_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("processed item produced no result");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step_en |=> in_valid_reg)
        else $error("unprocessed item dropped from the item stage");

endmodule

// ----- test/proximity_alarm_controller_tb.sv -----
// Self-checking testbench for the proximity alarm controller: random traffic against a predictor.
`timescale 1ns / 100ps

module proximity_alarm_controller_tb;

    import pac_pkg::*;

    // Give up when this many cycles pass with no item moving on either channel.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Random items per configuration phase; six phases make at least 780 in total.
    localparam int unsigned PHASE_ITEMS = 130;
    localparam int          PHASE_COUNT = 6;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    pac_item_if   item_if ();
    pac_result_if result_if ();

    proximity_alarm_controller dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers and of the mode
    // machine, starting from the reset values.
    // ------------------------------------------------------------------
    pac_cfg_t    cfg = {COLOUR_A_RST, COLOUR_B_RST, BLINK_PERIOD_RST,
                        TRIGGER_DIST_RST, CLEAR_TIMEOUT_RST, TEST_DURATION_RST};
    mode_t       cur_mode   = MODE_OFF;
    logic        arm_req    = 1'b0;
    logic        disarm_req = 1'b0;
    logic [31:0] toggle_ms  = '0;
    logic [31:0] detect_ms  = '0;
    logic [31:0] test_t0    = '0;
    logic        phase      = 1'b0;
    logic [23:0] leds       = '0;
    logic        buzz       = 1'b0;

    // Items waiting for the driver, and the results the block owes us.
    pac_item_t   pending_items[$];
    pac_result_t due_results[$];
    pac_item_t   on_wire;
    pac_result_t want;

    int unsigned items_queued  = 0;
    int unsigned items_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned fail_count    = 0;
    int unsigned alarm_entries = 0;
    int unsigned test_entries  = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Stimulus timebase and the largest step it takes between items.
    logic [31:0] t_ms     = '0;
    int unsigned step_max = 300;

    // Free-running clock, 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the predictor by one item and return the result it owes.
    // Arm and disarm only latch; an update is interpreted by the current mode;
    // a test start overrides everything.
    function automatic pac_result_t alarm_step(pac_item_t it);
        pac_result_t r;
        logic [31:0] since_toggle;
        logic [31:0] since_detect;
        logic [31:0] since_test;
        logic        near;
        logic        far;
        since_toggle = it.now_ms - toggle_ms;
        since_detect = it.now_ms - detect_ms;
        since_test   = it.now_ms - test_t0;
        near = it.distance_valid && (it.distance_reading <= cfg.trigger_distance);
        far  = it.distance_valid && (it.distance_reading > cfg.trigger_distance);
        case (it.func)
            FUNC_ARM:    arm_req = 1'b1;
            FUNC_DISARM: disarm_req = 1'b1;
            FUNC_TEST:
            begin
                cur_mode = MODE_TEST;
                test_t0  = it.now_ms;
                leds     = RED_ONLY;
                buzz     = 1'b1;
                test_entries++;
            end
            default:
            begin
                case (cur_mode)
                    MODE_OFF:
                    begin
                        leds = '0;
                        buzz = 1'b0;
                        if (arm_req)
                        begin
                            arm_req  = 1'b0;
                            cur_mode = MODE_WATCH;
                        end
                    end
                    MODE_WATCH:
                    begin
                        leds = '0;
                        buzz = 1'b0;
                        // An invalid sample never fires the alarm.
                        if (near)
                        begin
                            cur_mode  = MODE_ALARM;
                            detect_ms = it.now_ms;
                            alarm_entries++;
                        end
                        if (disarm_req)
                        begin
                            disarm_req = 1'b0;
                            cur_mode   = MODE_OFF;
                        end
                    end
                    MODE_ALARM:
                    begin
                        // Toggle the colour once the blink period has run out;
                        // the LEDs stay dark until the first toggle.
                        if (since_toggle >= {16'd0, cfg.blink_period_ms})
                        begin
                            toggle_ms = it.now_ms;
                            phase     = ~phase;
                            leds      = phase ? cfg.colour_a : cfg.colour_b;
                        end
                        buzz = 1'b1;
                        // Only a valid far sample lets the clear timer run;
                        // anything else counts as a fresh detection.
                        if (far)
                        begin
                            if (since_detect >= cfg.clear_timeout_ms)
                            begin
                                cur_mode = MODE_WATCH;
                                leds     = '0;
                                buzz     = 1'b0;
                            end
                        end
                        else
                        begin
                            detect_ms = it.now_ms;
                        end
                        // Disarm leaves the levels as they are until the next update.
                        if (disarm_req)
                        begin
                            disarm_req = 1'b0;
                            cur_mode   = MODE_OFF;
                        end
                    end
                    default:
                    begin
                        if (since_test < cfg.test_duration_ms)
                        begin
                            leds = RED_ONLY;
                            buzz = 1'b1;
                        end
                        else
                        begin
                            cur_mode = MODE_OFF;
                            leds     = '0;
                            buzz     = 1'b0;
                        end
                    end
                endcase
            end
        endcase
        r.red       = leds[23:16];
        r.green     = leds[15:8];
        r.blue      = leds[7:0];
        r.buzzer_on = buzz;
        r.mode      = cur_mode;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer the next pending item whenever the slot is free and
    // the sender is not idling; predict each item as it is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
        end
        else
        begin
            if (item_if.valid && item_if.ready)
            begin
                due_results.push_back(alarm_step(on_wire));
                items_taken++;
            end
            if (!item_if.valid || item_if.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    on_wire = pending_items.pop_front();
                    item_if.valid            <= 1'b1;
                    item_if.func             <= on_wire.func;
                    item_if.now_ms           <= on_wire.now_ms;
                    item_if.distance_reading <= on_wire.distance_reading;
                    item_if.distance_valid   <= on_wire.distance_valid;
                end
                else
                begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation,
    // and stall the result channel at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    $error("result taken with no item outstanding (mode %0d)", result_if.mode);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("red", 32'(want.red), 32'(result_if.red));
                    check_field("green", 32'(want.green), 32'(result_if.green));
                    check_field("blue", 32'(want.blue), 32'(result_if.blue));
                    check_field("buzzer_on", 32'(want.buzzer_on), 32'(result_if.buzzer_on));
                    check_field("mode", 32'(want.mode), 32'(result_if.mode));
                end
            end
            result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles in which nothing moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timed out after %0d quiet cycles, %0d items still owed",
                         quiet_cycles, due_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_item(func_t f, logic [31:0] now, logic [15:0] sample, logic dvalid);
        pac_item_t it;
        it.func             = f;
        it.now_ms           = now;
        it.distance_reading = sample;
        it.distance_valid   = dvalid;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Write one register through the APB port: setup cycle, then access.
    task automatic reg_write(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COLOUR_A:      cfg.colour_a         = value[23:0];
            REG_COLOUR_B:      cfg.colour_b         = value[23:0];
            REG_BLINK_PERIOD:  cfg.blink_period_ms  = value[15:0];
            REG_TRIGGER_DIST:  cfg.trigger_distance = value[15:0];
            REG_CLEAR_TIMEOUT: cfg.clear_timeout_ms = value;
            default:           cfg.test_duration_ms = value;
        endcase
    endtask

    // Hold until every queued item has been taken and every result checked.
    task automatic drain;
        while (items_taken != items_queued || due_results.size() != 0)
            @(posedge clk);
    endtask

    // Move the timebase on; now and then jump anywhere so that differences wrap.
    task automatic step_time;
        if ($urandom_range(0, 63) == 0)
            t_ms = $urandom;
        else
            t_ms += $urandom_range(0, step_max);
    endtask

    // Pick a distance on the chosen side of the trigger, favouring its edges.
    task automatic pick_dist(bit close, output logic [15:0] sample);
        logic [15:0] trig;
        trig = cfg.trigger_distance;
        if (close)
        begin
            case ($urandom_range(0, 3))
                0:       sample = trig;
                1:       sample = 16'd0;
                default: sample = 16'($urandom_range(0, trig));
            endcase
        end
        else if (trig == 16'hFFFF)
        begin
            sample = 16'hFFFF;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       sample = trig + 16'd1;
                1:       sample = 16'hFFFF;
                default: sample = 16'($urandom_range(trig + 1, 16'hFFFF));
            endcase
        end
    endtask

    task automatic queue_update(bit close, int unsigned valid_pct);
        logic [15:0] sample;
        step_time();
        pick_dist(close, sample);
        add_item(FUNC_UPDATE, t_ms, sample, $urandom_range(0, 99) < valid_pct);
    endtask

    // Requests carry random distance fields that the block must disregard.
    task automatic queue_request(func_t f);
        step_time();
        add_item(f, t_ms, 16'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Fill one phase with sessions: mostly arm-detect-blink-clear sequences,
    // some self-tests ending right on the duration edge, and a little noise.
    task automatic fill_phase(int unsigned n);
        int unsigned goal;
        logic [31:0] t0;
        goal = items_queued + n;
        while (items_queued < goal)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    repeat ($urandom_range(1, 3))
                        add_item(func_t'($urandom_range(0, 3)), $urandom, 16'($urandom),
                                 1'($urandom_range(0, 1)));
                end
                1:
                begin
                    queue_request(FUNC_TEST);
                    t0 = t_ms;
                    repeat ($urandom_range(0, 4))
                        queue_update($urandom_range(0, 3) == 0, 80);
                    if ($urandom_range(0, 3) != 0)
                    begin
                        // Last millisecond of the test, then the first one past it.
                        add_item(FUNC_UPDATE, t0 + cfg.test_duration_ms - 1, 16'($urandom),
                                 1'b1);
                        add_item(FUNC_UPDATE, t0 + cfg.test_duration_ms, 16'($urandom), 1'b1);
                        t_ms = t0 + cfg.test_duration_ms;
                    end
                end
                default:
                begin
                    queue_request(FUNC_ARM);
                    queue_update(1'b0, 90);
                    repeat ($urandom_range(0, 3))
                        queue_update(1'b0, 70);
                    queue_update(1'b1, 100);
                    repeat ($urandom_range(2, 14))
                        queue_update($urandom_range(0, 3) == 0, 90);
                    if ($urandom_range(0, 2) == 0)
                    begin
                        queue_request(FUNC_DISARM);
                        queue_update(1'($urandom_range(0, 1)), 90);
                        queue_update(1'b0, 90);
                    end
                end
            endcase
        end
    endtask

    // Choose and write one register setting; phases 0 and 2 hit the extremes.
    task automatic apply_setting(int p);
        logic [23:0] col_a;
        logic [23:0] col_b;
        logic [15:0] blink;
        logic [15:0] trig;
        logic [31:0] clear_to;
        logic [31:0] dur;
        case (p)
            0:
            begin
                col_a = 24'hFFFFFF;  col_b = 24'h000000;
                blink = 16'hFFFF;    trig  = 16'hFFFF;
                clear_to = 32'hFFFFFFFF;  dur = 32'hFFFFFFFF;
                step_max = 30000;
            end
            2:
            begin
                col_a = 24'h000000;  col_b = 24'hFFFFFF;
                blink = 16'd0;       trig  = 16'd0;
                clear_to = 32'd0;    dur   = 32'd0;
                step_max = 3;
            end
            default:
            begin
                col_a    = 24'($urandom);
                col_b    = 24'($urandom);
                blink    = 16'($urandom_range(0, 40));
                trig     = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3000));
                clear_to = $urandom_range(0, 150);
                dur      = $urandom_range(0, 150);
                step_max = 60;
            end
        endcase
        reg_write(REG_COLOUR_A, {8'd0, col_a});
        reg_write(REG_COLOUR_B, {8'd0, col_b});
        reg_write(REG_BLINK_PERIOD, {16'd0, blink});
        reg_write(REG_TRIGGER_DIST, {16'd0, trig});
        reg_write(REG_CLEAR_TIMEOUT, clear_to);
        reg_write(REG_TEST_DURATION, dur);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Drive every input to a known value before the first edge.
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        item_if.valid            = 1'b0;
        item_if.func             = FUNC_UPDATE;
        item_if.now_ms           = '0;
        item_if.distance_reading = '0;
        item_if.distance_valid   = 1'b0;
        result_if.ready          = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles a third of the time, receiver most of it.
        send_idle_pct = 33;
        recv_idle_pct = 86;

        // Directed part with the reset settings: walk every mode, every
        // request, the pending flags, both sample kinds and the wrap of time.
        add_item(FUNC_UPDATE, 32'd0, 16'hFFFF, 1'b1);              // off stays dark
        add_item(FUNC_DISARM, 32'd0, 16'd0, 1'b0);                 // stays pending in off
        add_item(FUNC_ARM, 32'd5, 16'd0, 1'b0);
        add_item(FUNC_UPDATE, 32'd10, 16'hFFFF, 1'b1);             // arm taken: watching
        add_item(FUNC_UPDATE, 32'd20, 16'd0, 1'b1);                // detect, but old disarm wins
        add_item(FUNC_ARM, 32'd25, 16'd0, 1'b0);
        add_item(FUNC_UPDATE, 32'd30, 16'hFFFF, 1'b1);             // watching again
        add_item(FUNC_UPDATE, 32'd40, TRIGGER_DIST_RST, 1'b0);     // invalid: no detection
        add_item(FUNC_UPDATE, 32'd50, TRIGGER_DIST_RST, 1'b1);     // exactly at trigger: alarm
        add_item(FUNC_UPDATE, 32'd100, TRIGGER_DIST_RST + 16'd1, 1'b1); // dark until toggle
        add_item(FUNC_UPDATE, 32'd300, 16'hFFFF, 1'b0);            // toggle; invalid re-detects
        add_item(FUNC_UPDATE, 32'hFFFF_FFFF, 16'd2000, 1'b1);      // far long enough: clears
        add_item(FUNC_UPDATE, 32'd5, 16'd100, 1'b1);               // wrapped time, alarm again
        add_item(FUNC_UPDATE, 32'd260, 16'd100, 1'b1);             // toggle across the wrap
        add_item(FUNC_DISARM, 32'd265, 16'd0, 1'b0);
        add_item(FUNC_UPDATE, 32'd270, 16'd100, 1'b1);             // off, levels held
        add_item(FUNC_UPDATE, 32'd280, 16'd100, 1'b1);             // off clears levels
        add_item(FUNC_TEST, 32'd290, 16'd0, 1'b0);                 // red and buzzer
        add_item(FUNC_ARM, 32'd295, 16'd0, 1'b0);                  // not taken in test
        add_item(FUNC_UPDATE, 32'd3289, 16'd0, 1'b1);              // last test millisecond
        add_item(FUNC_UPDATE, 32'd3290, 16'd0, 1'b1);              // test over
        add_item(FUNC_UPDATE, 32'd3300, 16'd0, 1'b1);              // arm taken in off
        add_item(FUNC_TEST, 32'hFFFF_FFF0, 16'hFFFF, 1'b1);        // test from watching
        add_item(FUNC_UPDATE, 32'd100, 16'd0, 1'b1);               // still testing across wrap
        t_ms = 32'd100;
        drain();

        // Random phases, each under a fresh register setting.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 33;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(p);
            fill_phase(PHASE_ITEMS);
            drain();
        end

        // Allow for the block's latency so any stray result shows up.
        repeat (8) @(posedge clk);

        $display("Ran %0d items through %0d register settings, %0d results checked",
                 items_taken, PHASE_COUNT + 1, results_seen);
        $display("Alarm entered %0d times, self-test started %0d times",
                 alarm_entries, test_entries);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/pac_pkg.sv
rtl/core/pac_if.sv
rtl/core/pac_regs.sv
rtl/core/pac_core.sv
rtl/core/proximity_alarm_controller.sv
test/proximity_alarm_controller_tb.sv
